/* rtl/btmf_pkg.sv */
// Shared constants and types of the batched trimmed-mean ADC filter.
`default_nettype none
package btmf_pkg;

   localparam int SAMPLE_W         = 12;
   localparam int OUT_W            = 12;
   localparam int SAMPLE_COUNT_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 12;
   localparam int TAG_STAGES       = 3;

   typedef struct packed {
      logic take;
      logic first;
   } lane_ctrl_type;

   typedef struct packed {
      logic valid;
      logic pair;
      logic next_pair;
   } merge_tag_type;

   typedef struct packed {
      logic room;
   } merge_status_type;

endpackage
`default_nettype wire

/* rtl/btmf_if.sv */
// Request and response channel interfaces of the trimmed-mean filter.
`default_nettype none
interface btmf_req_if import btmf_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_first;
   logic [SAMPLE_W-1:0] sample_second;

   modport source (output valid, output sample_first, output sample_second, input ready);
   modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

interface btmf_rsp_if import btmf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] channel0_value;
   logic [OUT_W-1:0] channel1_value;
   logic [OUT_W-1:0] channel2_value;
   logic             next_group_is_pair;

   modport source (output valid, output channel0_value, output channel1_value,
                   output channel2_value, output next_group_is_pair, input ready);
   modport sink   (input valid, input channel0_value, input channel1_value,
                   input channel2_value, input next_group_is_pair, output ready);
endinterface
`default_nettype wire

/* rtl/btmf_lane.sv */
// One channel lane: running max/min/sum, trim and divide by reciprocal multiply.
`default_nettype none
module btmf_lane import btmf_pkg::*; #(
   parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  wire logic                clock,
   input  wire lane_ctrl_type       ctrl,
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic      [OUT_W-1:0]    mean
);

   localparam int InW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SumW  = SAMPLE_BITS + $clog2(SAMPLE_COUNT + 1);
   localparam bit Trim  = (SAMPLE_COUNT > 2);
   localparam int Div   = Trim ? (SAMPLE_COUNT - 2) : 2;
   localparam int DivL  = $clog2(Div);
   localparam int Shift = SumW + DivL;
   localparam int RecW  = Shift + 1;
   localparam int ProdW = ((SumW + RecW) > (Shift + OUT_W)) ? (SumW + RecW) : (Shift + OUT_W);
   localparam longint RecipL = ((64'd1 << Shift) / Div) + 1;
   localparam logic [RecW-1:0] Recip = RecipL[RecW-1:0];

   logic [SAMPLE_BITS-1:0] v;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SumW-1:0]        sum_ff, sum_in;
   logic [SumW-1:0]        diff_ff, diff_in;
   logic [ProdW-1:0]       prod_ff, prod_in;

   always_comb begin
      v = '0;
      v[InW-1:0] = sample[InW-1:0];
      max_in = max_ff;
      min_in = min_ff;
      sum_in = sum_ff;
      if (ctrl.take) begin
         if (ctrl.first) begin
            max_in = v;
            min_in = v;
            sum_in = SumW'(v);
         end else begin
            max_in = (v > max_ff) ? v : max_ff;
            min_in = (v < min_ff) ? v : min_ff;
            sum_in = sum_ff + SumW'(v);
         end
      end
   end

   // sum - max - min is never negative once the batch holds both extremes
   assign diff_in = Trim ? (sum_ff - SumW'(max_ff) - SumW'(min_ff)) : sum_ff;
   assign prod_in = ProdW'(diff_ff) * ProdW'(Recip);

   always_ff @(posedge clock) begin
      max_ff  <= max_in;
      min_ff  <= min_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   assign mean = prod_ff[Shift +: OUT_W];

endmodule
`default_nettype wire

/* rtl/btmf_merge.sv */
// Merge stage: held channel values and the two-entry result buffer.
`default_nettype none
module btmf_merge import btmf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire merge_tag_type    tag,
   input  wire logic [OUT_W-1:0] mean0,
   input  wire logic [OUT_W-1:0] mean1,
   output merge_status_type      status,
   btmf_rsp_if.source            rsp
);

   typedef struct packed {
      logic [OUT_W-1:0] ch0;
      logic [OUT_W-1:0] ch1;
      logic [OUT_W-1:0] ch2;
      logic             next_pair;
   } result_type;

   merge_tag_type    tag_ff [TAG_STAGES];
   logic [OUT_W-1:0] held_ff [3];
   logic [OUT_W-1:0] held_in [3];
   result_type       ent_ff [2];
   result_type       ent_in;
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [2:0]       pend;
   logic             push, pop;

   assign push = tag_ff[TAG_STAGES-1].valid;
   assign pop  = rsp.valid & rsp.ready;

   always_comb begin
      held_in = held_ff;
      if (push) begin
         if (tag_ff[TAG_STAGES-1].pair) begin
            held_in[1] = mean0;
            held_in[2] = mean1;
         end else begin
            held_in[0] = mean0;
         end
      end
      ent_in.ch0       = held_in[0];
      ent_in.ch1       = held_in[1];
      ent_in.ch2       = held_in[2];
      ent_in.next_pair = tag_ff[TAG_STAGES-1].next_pair;
   end

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // in-flight batches plus buffered results must fit in the buffer
   always_comb begin
      pend = 3'(cnt_ff);
      for (int i = 0; i < TAG_STAGES; i++) begin
         pend = pend + 3'(tag_ff[i].valid);
      end
      status.room = (pend < 3'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAG_STAGES; i++) begin
            tag_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= '0;
         end
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         tag_ff[0] <= tag;
         for (int i = 1; i < TAG_STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         held_ff <= held_in;
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= ent_in;
      end
   end

   assign rsp.valid              = (cnt_ff != 2'd0);
   assign rsp.channel0_value     = ent_ff[rd_ff].ch0;
   assign rsp.channel1_value     = ent_ff[rd_ff].ch1;
   assign rsp.channel2_value     = ent_ff[rd_ff].ch2;
   assign rsp.next_group_is_pair = ent_ff[rd_ff].next_pair;

endmodule
`default_nettype wire

/* rtl/batched_trimmed_mean_adc_filter_top.sv */
// Top level: batch sequencing, two sample lanes and the merge stage.
// One beat accepted per cycle while ready is high; a beat ending a batch shows its result
// after the lane pipeline: accumulate, trim, reciprocal multiply, merge.
// Beats inside a batch are never stalled; a batch-ending beat waits for buffer room.
// Synchronous reset: pair group first, count and held values cleared, buffer empty.
`default_nettype none
module batched_trimmed_mean_adc_filter_top import btmf_pkg::*; #(
   parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   btmf_req_if.sink   req,
   btmf_rsp_if.source rsp
);

   localparam int CntW = $clog2(SAMPLE_COUNT);

   logic [CntW-1:0]  count_ff, count_in;
   logic             group_ff, group_in;
   logic             toggle_ff, toggle_in;
   logic             fire, last_slot;
   lane_ctrl_type    ctrl0, ctrl1;
   merge_tag_type    tag;
   merge_status_type status;
   logic [OUT_W-1:0] mean0, mean1;

   assign last_slot = (count_ff == CntW'(SAMPLE_COUNT - 1));
   assign req.ready = ~last_slot | status.room;
   assign fire      = req.valid & req.ready;

   always_comb begin
      count_in  = count_ff;
      group_in  = group_ff;
      toggle_in = toggle_ff;
      if (fire) begin
         if (last_slot) begin
            count_in  = '0;
            toggle_in = ~toggle_ff;
            group_in  = ~toggle_ff;
         end else begin
            count_in = count_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         group_ff  <= 1'b1;
         toggle_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         group_ff  <= group_in;
         toggle_ff <= toggle_in;
      end
   end

   always_comb begin
      ctrl0.take    = fire;
      ctrl0.first   = (count_ff == '0);
      ctrl1.take    = fire & group_ff;
      ctrl1.first   = (count_ff == '0);
      tag.valid     = fire & last_slot;
      tag.pair      = group_ff;
      tag.next_pair = ~toggle_ff;
   end

   btmf_lane #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_lane0 (
      .clock  (clock),
      .ctrl   (ctrl0),
      .sample (req.sample_first),
      .mean   (mean0)
   );

   btmf_lane #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_lane1 (
      .clock  (clock),
      .ctrl   (ctrl1),
      .sample (req.sample_second),
      .mean   (mean1)
   );

   btmf_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag),
      .mean0  (mean0),
      .mean1  (mean1),
      .status (status),
      .rsp    (rsp)
   );

   // a batch-ending beat always produces a visible result
   a_batch_result: assert property (@(posedge clock) disable iff (reset)
      fire && last_slot |-> ##4 rsp.valid)
      else $error("batch end did not produce a result");

   // results only appear after a batch-ending beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(fire && last_slot, 4))
      else $error("result without a batch end");

endmodule
`default_nettype wire

/* dv/tb_batched_trimmed_mean_adc_filter_top.sv */
// Self-checking testbench of the batched trimmed-mean ADC filter top level.
module tb_batched_trimmed_mean_adc_filter_top;
   import btmf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BATCH_LEN    = SAMPLE_COUNT_DEF;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_BEATS = 608;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [OUT_W-1:0] ch0;
      logic [OUT_W-1:0] ch1;
      logic [OUT_W-1:0] ch2;
      logic             next_pair;
   } held_means_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample_first;
      logic [SAMPLE_W-1:0] sample_second;
      bit                  typed;
      held_means_type      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   btmf_req_if req_ch ();
   btmf_rsp_if rsp_ch ();

   batched_trimmed_mean_adc_filter_top #(
      .SAMPLE_COUNT (BATCH_LEN),
      .SAMPLE_BITS  (SAMPLE_BITS_DEF)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #1 clock = ~clock;

   // filter state mirror
   logic                grp_pair;
   logic                batch_flip;
   int unsigned         evt_count;
   logic [SAMPLE_W-1:0] lane_max [2];
   logic [SAMPLE_W-1:0] lane_min [2];
   int unsigned         lane_sum [2];
   logic [OUT_W-1:0]    held [3];

   held_means_type pending_means [$];
   int             mismatches;
   int             beats_sent;
   int             results_seen;
   int             input_stalls;
   int             src_idle_pct;
   int             sink_idle_pct;
   int             hold_request;
   int             hold_left;

   // pair, pair, single: full scale, split rails, alternating extremes
   stim_row_type directed_rows [24] = '{
      '{12'hFFF, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'hFFF, 1'b0, '0},
      '{12'hFFF, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'hFFF, 1'b0, '0},
      '{12'hFFF, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'hFFF, 1'b0, '0},
      '{12'hFFF, 12'hFFF, 1'b0, '0},
      '{12'hFFF, 12'hFFF, 1'b1, '{12'd0, 12'd4095, 12'd4095, 1'b1}},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'h000, 12'hFFF, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'h000, 12'hFFF, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'h000, 12'hFFF, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b1, '{12'd0, 12'd0, 12'd4095, 1'b0}},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'h000, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'h000, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0}, '{12'hFFF, 12'h000, 1'b0, '0},
      '{12'h000, 12'hFFF, 1'b0, '0},
      '{12'hFFF, 12'h000, 1'b1, '{12'd2047, 12'd0, 12'd4095, 1'b1}}
   };

   function automatic void clear_filter_state();
      grp_pair   = 1'b1;
      batch_flip = 1'b0;
      evt_count  = 0;
      for (int s = 0; s < 2; s++) begin
         lane_max[s] = '0;
         lane_min[s] = '0;
         lane_sum[s] = 0;
      end
      for (int c = 0; c < 3; c++) held[c] = '0;
   endfunction

   function automatic void absorb_sample(int slot, logic [SAMPLE_W-1:0] v, bit opening);
      if (opening) begin
         lane_max[slot] = v;
         lane_min[slot] = v;
         lane_sum[slot] = 32'(v);
      end else begin
         if (v > lane_max[slot]) lane_max[slot] = v;
         if (v < lane_min[slot]) lane_min[slot] = v;
         lane_sum[slot] += 32'(v);
      end
   endfunction

   function automatic logic [OUT_W-1:0] trimmed_mean(int slot);
      int unsigned s;
      s = lane_sum[slot];
      if (BATCH_LEN > 2) s = (s - lane_max[slot] - lane_min[slot]) / (BATCH_LEN - 2);
      else s = s / 2;
      return s[OUT_W-1:0];
   endfunction

   // steps the mirror by one conversion event; returns 1 when a batch closes
   function automatic bit filter_event(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                       output held_means_type r);
      bit opening;
      opening = (evt_count == 0);
      r = '0;
      absorb_sample(0, a, opening);
      if (grp_pair) absorb_sample(1, b, opening);
      evt_count = (evt_count + 1) & 32'h7F;
      if (evt_count < BATCH_LEN) return 1'b0;
      evt_count = 0;
      if (grp_pair) begin
         held[1] = trimmed_mean(0);
         held[2] = trimmed_mean(1);
      end else begin
         held[0] = trimmed_mean(0);
      end
      batch_flip = ~batch_flip;
      grp_pair   = batch_flip;
      r.ch0       = held[0];
      r.ch1       = held[1];
      r.ch2       = held[2];
      r.next_pair = grp_pair;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] next_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'($urandom_range(15));
         3: return SAMPLE_W'(4095 - $urandom_range(15));
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   function automatic void check_result(held_means_type got);
      held_means_type want;
      if (pending_means.size() == 0) begin
         note_mismatch($sformatf("unexpected result %p", got));
         return;
      end
      want = pending_means.pop_front();
      if (got.ch0 !== want.ch0)
         note_mismatch($sformatf("channel0_value exp %0d got %0d", want.ch0, got.ch0));
      if (got.ch1 !== want.ch1)
         note_mismatch($sformatf("channel1_value exp %0d got %0d", want.ch1, got.ch1));
      if (got.ch2 !== want.ch2)
         note_mismatch($sformatf("channel2_value exp %0d got %0d", want.ch2, got.ch2));
      if (got.next_pair !== want.next_pair)
         note_mismatch($sformatf("next_group_is_pair exp %0b got %0b",
                                 want.next_pair, got.next_pair));
   endfunction

   task automatic send_beat(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
      bit took;
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample_first  <= a;
      req_ch.sample_second <= b;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         if (!took) input_stalls++;
         @(posedge clock);
      end while (!took);
      beats_sent++;
   endtask

   task automatic run_random(input int n);
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] b;
      held_means_type      r;
      for (int i = 0; i < n; i++) begin
         a = next_sample();
         b = next_sample();
         send_beat(a, b);
         if (filter_event(a, b, r)) pending_means.push_back(r);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         check_result('{rsp_ch.channel0_value, rsp_ch.channel1_value,
                        rsp_ch.channel2_value, rsp_ch.next_group_is_pair});
      end
   end

   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      held_means_type r;
      bit             closed;
      req_ch.valid         = 1'b0;
      req_ch.sample_first  = '0;
      req_ch.sample_second = '0;
      rsp_ch.ready         = 1'b0;
      mismatches    = 0;
      beats_sent    = 0;
      results_seen  = 0;
      input_stalls  = 0;
      hold_request  = 0;
      hold_left     = 0;
      src_idle_pct  = 35;
      sink_idle_pct = 69;
      clear_filter_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].sample_first, directed_rows[i].sample_second);
         closed = filter_event(directed_rows[i].sample_first,
                               directed_rows[i].sample_second, r);
         if (directed_rows[i].typed) pending_means.push_back(directed_rows[i].want);
         else if (closed) pending_means.push_back(r);
      end
      run_random(RANDOM_BEATS);
      wait_drained();

      src_idle_pct  = 69;
      sink_idle_pct = 35;
      run_random(RANDOM_BEATS);
      wait_drained();

      // long sink hold-off while beats keep coming: output buffer fills up
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      run_random(RANDOM_BEATS);
      req_ch.valid <= 1'b0;

      while (pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sample beats in pair and single batches of %0d, checked %0d results",
               beats_sent, BATCH_LEN, results_seen);
      $display("Input back-pressure seen on %0d cycles, %0d mismatches",
               input_stalls, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/btmf_pkg.sv
rtl/btmf_if.sv
rtl/btmf_lane.sv
rtl/btmf_merge.sv
rtl/batched_trimmed_mean_adc_filter_top.sv
dv/tb_batched_trimmed_mean_adc_filter_top.sv
